// ----- design/asidrs_pkg.sv -----
// Shared types and constants of the identifier allocator.
package asidrs_pkg;

   localparam int MAX_ASID_BITS_DEF = 8;
   localparam int OWNER_BITS_DEF    = 16;

   localparam int CSR_W    = 4;
   localparam int ASID_W   = 8;
   localparam int HANDLE_W = 16;

   localparam logic [CSR_W-1:0] ID_LOG2_RESET = 4'd8;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef struct packed {
      logic                func;
      logic [HANDLE_W-1:0] owner;
      logic [ASID_W-1:0]   held_asid;
      logic                held_valid;
   } req_type;

   typedef struct packed {
      logic [ASID_W-1:0]   asid;
      logic                flush;
      logic                stolen;
      logic [HANDLE_W-1:0] victim_owner;
      logic                victim_valid;
   } rsp_type;

endpackage

// ----- design/asidrs_owner_mem.sv -----
// Owner table: single-port-write, registered-read memory of owner handles.
module asidrs_owner_mem #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] owner_mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= owner_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/asidrs_free_search.sv -----
// Occupancy bitmap with a two-level lowest-free-identifier search.
module asidrs_free_search #(
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W:0]   id_count,
   input  logic              set_en,
   input  logic              clr_en,
   input  logic [ADDR_W-1:0] upd_idx,
   input  logic [ADDR_W-1:0] query_idx,
   output logic              query_occ,
   output logic              found,
   output logic [ADDR_W-1:0] found_idx
);

   localparam int DEPTH = 1 << ADDR_W;
   localparam int GRP   = (DEPTH < 16) ? DEPTH : 16;
   localparam int NGRP  = DEPTH / GRP;
   localparam int GRP_W = $clog2(GRP);

   logic [DEPTH-1:0] occ_ff;
   logic [DEPTH-1:0] free_vec;
   logic [NGRP-1:0]  grp_any_in;
   logic [NGRP-1:0]  grp_any_ff;
   logic [GRP_W-1:0] grp_idx_in [NGRP];
   logic [GRP_W-1:0] grp_idx_ff [NGRP];

   // Hold one occupancy bit per identifier; reset frees them all at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (set_en) begin
         occ_ff[upd_idx] <= 1'b1;
      end else if (clr_en) begin
         occ_ff[upd_idx] <= 1'b0;
      end
   end

   assign query_occ = occ_ff[query_idx];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         free_vec[i] = !occ_ff[i] && (i != 0) && ((ADDR_W+1)'(i) < id_count);
      end
   end

   // First level: lowest free entry within each group, registered.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int k = GRP - 1; k >= 0; k--) begin
            if (free_vec[g*GRP + k]) begin
               grp_any_in[g] = 1'b1;
               grp_idx_in[g] = GRP_W'(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_idx_ff <= grp_idx_in;
   end

   // Second level: lowest group that has a free entry.
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found     = 1'b1;
            found_idx = (ADDR_W'(g) << GRP_W) | ADDR_W'(grp_idx_ff[g]);
         end
      end
   end

endmodule

// ----- design/asid_alloc_with_rotor_steal_unit.sv -----
// Top level of the address space identifier allocator with rotor stealing.
//
// Hands out address space identifiers to owners. An allocate transaction
// with a nonzero owner takes the lowest free identifier from 1 up to
// 2^id_log2 - 1; when none is free the steal rotor advances (wrapping to 1)
// and the identifier under it is taken, with a flush requested and, if it
// was occupied, its previous owner reported. A release with held_valid set
// frees the identifier the owner says it holds and requests a flush.
// Identifier 0 is global and is never allocated. A transaction passes the
// accept, look-up and decide states: look-up encodes the occupancy bitmap
// per group and reads the owner table at the steal candidate; decide
// resolves the lowest free group, writes back the table, bitmap and rotor
// and loads the output register. The next request is accepted in the cycle
// after write-back, so no request is taken while one is in flight; the
// read-modify-write of the owner table and its bitmap requires this. The
// output register lets the result wait for the consumer while the next
// request is taken; write-back stalls only if the previous result is still
// unread. The occupancy bitmap clears in the reset cycle itself, so there
// is no clearing pass. The user must write the identifier-width register
// id_log2 through the csr_ port only while idle; the block does not enforce
// it. Values below 1 act as 1 and above MAX_ASID_BITS act as MAX_ASID_BITS.
module asid_alloc_with_rotor_steal_unit #(
   parameter int MAX_ASID_BITS = asidrs_pkg::MAX_ASID_BITS_DEF,
   parameter int OWNER_BITS    = asidrs_pkg::OWNER_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  asidrs_pkg::req_type          req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output asidrs_pkg::rsp_type          rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [asidrs_pkg::CSR_W-1:0] csr_data
);

   import asidrs_pkg::*;

   localparam int DEPTH = 1 << MAX_ASID_BITS;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOK   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [1:0]               state_ff, state_in;
   req_type                  req_ff;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CSR_W-1:0]         id_log2_ff;
   logic [MAX_ASID_BITS-1:0] rotor_ff, rotor_in;

   logic [4:0]               bits_eff;
   logic [MAX_ASID_BITS:0]   id_count;
   logic [MAX_ASID_BITS:0]   rotor_next;
   logic [MAX_ASID_BITS-1:0] steal_slot;

   logic                     mem_we;
   logic [MAX_ASID_BITS-1:0] mem_waddr;
   logic [OWNER_BITS-1:0]    mem_rdata;
   logic [OWNER_BITS-1:0]    owner_w;

   logic                     set_en, clr_en;
   logic [MAX_ASID_BITS-1:0] upd_idx;
   logic                     slot_occ;
   logic                     found;
   logic [MAX_ASID_BITS-1:0] found_idx;

   logic                     commit;
   logic                     held_in_range;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Clamp the configured width, then form the identifier count.
   always_comb begin
      if (id_log2_ff == '0) begin
         bits_eff = 5'd1;
      end else if (32'(id_log2_ff) > MAX_ASID_BITS) begin
         bits_eff = 5'(MAX_ASID_BITS);
      end else begin
         bits_eff = 5'(id_log2_ff);
      end
      id_count = (MAX_ASID_BITS+1)'(1) << bits_eff;
   end

   // Candidate for a steal: rotor plus one, wrapped back to the first id.
   always_comb begin
      rotor_next = {1'b0, rotor_ff} + (MAX_ASID_BITS+1)'(1);
      if (rotor_next >= id_count) begin
         steal_slot = MAX_ASID_BITS'(1);
      end else begin
         steal_slot = rotor_next[MAX_ASID_BITS-1:0];
      end
   end

   assign owner_w       = OWNER_BITS'(req_ff.owner);
   assign held_in_range = (32'(req_ff.held_asid) < DEPTH);
   assign commit        = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);

   asidrs_owner_mem #(
      .ADDR_W (MAX_ASID_BITS),
      .DATA_W (OWNER_BITS)
   ) u_owner_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (owner_w),
      .rd_addr (steal_slot),
      .rd_data (mem_rdata)
   );

   asidrs_free_search #(
      .ADDR_W (MAX_ASID_BITS)
   ) u_free_search (
      .clock     (clock),
      .reset     (reset),
      .id_count  (id_count),
      .set_en    (set_en),
      .clr_en    (clr_en),
      .upd_idx   (upd_idx),
      .query_idx (steal_slot),
      .query_occ (slot_occ),
      .found     (found),
      .found_idx (found_idx)
   );

   // Decide the transaction and build its write-back and result.
   always_comb begin
      state_in     = state_ff;
      rotor_in     = rotor_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = found_idx;
      set_en       = 1'b0;
      clr_en       = 1'b0;
      upd_idx      = found_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (req_ff.func == FUNC_ALLOC) begin
                  if (owner_w != '0) begin
                     mem_we = 1'b1;
                     set_en = 1'b1;
                     if (found) begin
                        rsp_in.asid = ASID_W'(found_idx);
                     end else begin
                        // Table full: steal the slot under the advanced rotor.
                        rotor_in     = steal_slot;
                        mem_waddr    = steal_slot;
                        upd_idx      = steal_slot;
                        rsp_in.asid  = ASID_W'(steal_slot);
                        rsp_in.flush = 1'b1;
                        if (slot_occ) begin
                           rsp_in.stolen       = 1'b1;
                           rsp_in.victim_valid = 1'b1;
                           rsp_in.victim_owner = HANDLE_W'(mem_rdata);
                        end
                     end
                  end
               end else if (req_ff.held_valid) begin
                  upd_idx      = MAX_ASID_BITS'(req_ff.held_asid);
                  clr_en       = held_in_range;
                  rsp_in.asid  = req_ff.held_asid;
                  rsp_in.flush = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rotor_ff     <= MAX_ASID_BITS'(1);
         id_log2_ff   <= ID_LOG2_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rotor_ff     <= rotor_in;
         if (csr_valid) begin
            id_log2_ff <= csr_data;
         end
      end
   end

   // Capture the request on acceptance and hold it for the whole transaction.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

endmodule
